// ----- rtl/datagram_slot_table_age_evict_defines.svh -----
// Assertion macros for the datagram slot table.
// Used by datagram_slot_table_age_evict.sv; expects clk and rst in scope.
`ifndef DATAGRAM_SLOT_TABLE_AGE_EVICT_DEFINES_SVH
`define DATAGRAM_SLOT_TABLE_AGE_EVICT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DSTAE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define DSTAE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/dstae_pkg.sv -----
// Package for the datagram slot table: item types, request codes, constants.
// No dependencies; used by datagram_slot_table_age_evict.sv.
`timescale 1ns / 1ps

package dstae_pkg;

  // default table geometry
  localparam int SLOT_COUNT_DEF = 32;
  localparam int SLOT_SIZE_DEF  = 512;

  // fixed constants of the slot format
  localparam int HDR_BYTES  = 48;
  localparam int LEN_PREFIX = 2;
  localparam logic [31:0] AGE_RESET = 32'd10000;
  localparam logic [31:0] STAMP_MAX = 32'hffff_ffff;
  localparam int FIT_MAX   = 63;
  localparam int TOTAL_MAX = 16383;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_AGE    = 2'd1;
  localparam logic [1:0] REQ_FIT    = 2'd2;
  localparam logic [1:0] REQ_FIRST  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [15:0] payload_len;
    logic [23:0] buffer_bytes;
  } dstae_in_t;

  typedef struct packed {
    logic [4:0]  slot_index;
    logic        slot_found;
    logic        evicted;
    logic [5:0]  fit_count;
    logic [13:0] total_bytes;
  } dstae_out_t;

endpackage

// ----- rtl/datagram_slot_table_age_evict.sv -----
// Datagram slot table with age-based eviction: insert, age-out, fit query and
// first-occupied lookup over SLOT_COUNT slots. An item is accepted only in
// the idle state, so the next item waits until the last one is through: the
// sequencer walks the stamp and byte-count memories one slot per cycle
// through their single read port, feeding one shared compare unit; the done
// step then updates the table and loads the output register once it is free.
// A result may wait in the output register while the next item is accepted.
// Depends on dstae_pkg and datagram_slot_table_age_evict_defines.svh.
`timescale 1ns / 1ps
`include "datagram_slot_table_age_evict_defines.svh"

module datagram_slot_table_age_evict #(
  parameter int SLOT_COUNT = dstae_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_SIZE  = dstae_pkg::SLOT_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [31:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dstae_pkg::dstae_in_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dstae_pkg::dstae_out_t out_item
);
  import dstae_pkg::*;

  localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int BYTES_W = $clog2(SLOT_SIZE);
  localparam int TOT_LIM = SLOT_COUNT * (SLOT_SIZE - 2);
  localparam int TOT_W   = $clog2(TOT_LIM + 1);
  localparam int CAP     = SLOT_SIZE - HDR_BYTES - LEN_PREFIX;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // control state
  logic [1:0]            state;
  logic [31:0]           age_limit;
  logic [SLOT_COUNT-1:0] occ;
  logic [TOT_W-1:0]      total;
  logic [CNT_W-1:0]      rd_cnt;
  logic                  s_vld;

  // latched item and scan results
  logic [1:0]         req_q;
  logic [31:0]        now_q;
  logic [15:0]        plen_q;
  logic [23:0]        buf_q;
  logic               pick_found;
  logic [IDX_W-1:0]   pick_idx;
  logic [31:0]        old_stamp;
  logic [IDX_W-1:0]   old_idx;
  logic [BYTES_W-1:0] old_bytes;
  logic [23:0]        used;
  logic [CNT_W-1:0]   fit;
  logic               fit_stop;

  // slot memories and their registered read data
  logic [31:0]        stamp_mem [SLOT_COUNT];
  logic [BYTES_W-1:0] bytes_mem [SLOT_COUNT];
  logic [31:0]        stamp_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [IDX_W-1:0]   s_idx;

  logic               issue;
  logic               occ_cur;
  logic [31:0]        cmp_a;
  logic [31:0]        cmp_b;
  logic               cmp_ge;
  logic [24:0]        fit_sum;
  logic [15:0]        plen_clamp;
  logic [BYTES_W-1:0] new_bytes;
  logic               do_write;
  logic               out_free;
  logic [IDX_W-1:0]   wr_idx;
  logic [TOT_W-1:0]   total_next;
  dstae_out_t         res;

  assign in_ready = (state == ST_IDLE);
  assign issue    = (state == ST_SCAN) && (rd_cnt < CNT_W'(SLOT_COUNT));
  assign occ_cur  = occ[s_idx];
  assign out_free = !out_valid || out_ready;

  // shared compare unit: cmp_a >= cmp_b, operands chosen by request
  assign fit_sum = {1'b0, used} + 25'(bytes_q) + 25'(LEN_PREFIX);
  always_comb begin
    case (req_q)
      REQ_INSERT: begin
        cmp_a = stamp_q;
        cmp_b = old_stamp;
      end
      REQ_AGE: begin
        cmp_a = now_q - stamp_q;
        cmp_b = age_limit;
      end
      REQ_FIT: begin
        cmp_a = 32'(buf_q);
        cmp_b = 32'(fit_sum);
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end
  assign cmp_ge = (cmp_a >= cmp_b);

  // insert data: clamped length, target slot, new total
  assign plen_clamp = (plen_q < 16'(CAP)) ? plen_q : 16'(CAP);
  assign new_bytes  = BYTES_W'(HDR_BYTES) + BYTES_W'(plen_clamp);
  assign do_write   = (req_q == REQ_INSERT) && (plen_q != 16'd0);
  assign wr_idx     = pick_found ? pick_idx : old_idx;
  assign total_next = total - (pick_found ? TOT_W'(0) : TOT_W'(old_bytes))
                    + TOT_W'(new_bytes);

  // result assembly
  always_comb begin
    res = '0;
    case (req_q)
      REQ_INSERT: begin
        if (do_write) begin
          res.slot_index  = 5'(wr_idx);
          res.slot_found  = 1'b1;
          res.evicted     = !pick_found;
          res.total_bytes = (total_next > TOT_W'(TOTAL_MAX)) ? 14'(TOTAL_MAX)
                                                             : 14'(total_next);
        end else begin
          // empty packet leaves the table as it was
          res.total_bytes = (total > TOT_W'(TOTAL_MAX)) ? 14'(TOTAL_MAX) : 14'(total);
        end
      end
      REQ_FIT: begin
        res.fit_count   = (fit > CNT_W'(FIT_MAX)) ? 6'(FIT_MAX) : 6'(fit);
        res.total_bytes = (total > TOT_W'(TOTAL_MAX)) ? 14'(TOTAL_MAX) : 14'(total);
      end
      REQ_FIRST: begin
        res.slot_index  = pick_found ? 5'(pick_idx) : 5'd0;
        res.slot_found  = pick_found;
        res.total_bytes = (total > TOT_W'(TOTAL_MAX)) ? 14'(TOTAL_MAX) : 14'(total);
      end
      default: begin
        res.total_bytes = (total > TOT_W'(TOTAL_MAX)) ? 14'(TOTAL_MAX) : 14'(total);
      end
    endcase
  end

  // slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free && do_write) begin
      stamp_mem[wr_idx] <= now_q;
      bytes_mem[wr_idx] <= new_bytes;
    end
    if (issue) begin
      stamp_q <= stamp_mem[rd_cnt[IDX_W-1:0]];
      bytes_q <= bytes_mem[rd_cnt[IDX_W-1:0]];
    end
    s_idx <= rd_cnt[IDX_W-1:0];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= AGE_RESET;
    end else if (cfg_wen) begin
      age_limit <= cfg_wdata;
    end
  end

  // sequencer, table flags and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      occ    <= '0;
      total  <= '0;
      rd_cnt <= '0;
      s_vld  <= 1'b0;
    end else begin
      s_vld <= issue;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SCAN;
            rd_cnt <= '0;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end else begin
            state <= ST_DONE;
          end
          if (s_vld && req_q == REQ_AGE && occ_cur && cmp_ge) begin
            occ[s_idx] <= 1'b0;
            total      <= total - TOT_W'(bytes_q);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (do_write) begin
              occ[wr_idx] <= 1'b1;
              total       <= total_next;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item latch and per-slot scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q      <= in_item.req_type;
      now_q      <= in_item.now_ms;
      plen_q     <= in_item.payload_len;
      buf_q      <= in_item.buffer_bytes;
      pick_found <= 1'b0;
      pick_idx   <= '0;
      old_stamp  <= STAMP_MAX;
      old_idx    <= '0;
      old_bytes  <= '0;
      used       <= 24'(LEN_PREFIX);
      fit        <= '0;
      fit_stop   <= 1'b0;
    end else if (state == ST_SCAN && s_vld) begin
      case (req_q)
        REQ_INSERT: begin
          if (!pick_found) begin
            if (!occ_cur) begin
              pick_found <= 1'b1;
              pick_idx   <= s_idx;
            end else if (!cmp_ge || s_idx == '0) begin
              // slot 0 always seeds the oldest pick, even with an all-ones stamp
              old_stamp <= stamp_q;
              old_idx   <= s_idx;
              old_bytes <= bytes_q;
            end
          end
        end
        REQ_FIT: begin
          if (occ_cur && !fit_stop) begin
            if (cmp_ge) begin
              fit  <= fit + CNT_W'(1);
              used <= fit_sum[23:0];
            end else begin
              fit_stop <= 1'b1;
            end
          end
        end
        REQ_FIRST: begin
          if (occ_cur && !pick_found) begin
            pick_found <= 1'b1;
            pick_idx   <= s_idx;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_item <= res;
    end
  end

  // checks
  `DSTAE_ASSERT_NEXT(a_accept_starts_scan, in_valid && in_ready, state == ST_SCAN, "accepted item did not start a scan")
  `DSTAE_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state) == ST_DONE, "result loaded outside the done step")
  `DSTAE_ASSERT_NOW(a_total_bounded, 1'b1, total <= TOT_W'(TOT_LIM), "stored byte total beyond table capacity")
  `DSTAE_ASSERT_NOW(a_fit_bounded, state != ST_IDLE, fit <= CNT_W'(SLOT_COUNT), "fit count beyond slot count")
  `DSTAE_ASSERT_NOW(a_evict_has_slot, out_valid && out_item.evicted, out_item.slot_found, "eviction reported without a slot")

endmodule
